### sv/fpa_pkg.sv
// Shared types and constants of the first-fit pool allocator.
package fpa_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MEMORY = 3'd3,
        ST_DOUBLE    = 3'd4,
        ST_BAD_ADDR  = 3'd5,
        ST_LIST_FULL = 3'd6
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [16:0] MIN_POOL  = 17'd4096;
    localparam int          ADDR_SPAN = 65536;

endpackage

### sv/fpa_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/first_fit_pool_allocator.sv
// Top level of the first-fit pool allocator: request sequencer and register port.
//
// Requests enter on the s_axis channel: tuser carries the operation (allocate or
// free), tdata the request size and the address. One result per request leaves
// on the m_axis channel through an output register, so the next request is taken
// while a result still waits. One request is worked on at a time.
// An allocate rejected at once goes straight to loading the result. A search of the
// free list reads one entry at a time from the newest entry down; on a hit, each
// younger entry is moved down to close the gap, then the search finishes and the
// result is loaded. On a miss, or at once with an empty list, the block is bump
// allocated and the result is loaded. A free scans the held entries for a double
// free, oldest first and stopping at a match, then checks the bounds, pushes the
// entry with its recorded size from the block size memory, and loads the result.
// The free list search sets the rate.
// Reset clears the bump offset, the free list count and the channels; the
// memories need no clearing. pool_size resets to min(POOL_BYTES, 65536).
// When the receiver stalls, the finished result holds in the output register.
module first_fit_pool_allocator
    import fpa_pkg::*;
#(
    parameter int POOL_BYTES   = 65536,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8,
    parameter int MAX_FREE     = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // request_size[15:0], address[31:16]
    input  logic        s_axis_tuser,  // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], granted_address[18:3], granted_size[34:19],
    // from_free_list[35], zero fill[39:36]
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POOL_CAP   = (POOL_BYTES < ADDR_SPAN) ? POOL_BYTES : ADDR_SPAN;
    localparam int SIZE_SLOTS = ADDR_SPAN / ALIGN_BYTES + 1;
    localparam int SW         = $clog2(SIZE_SLOTS);
    localparam int FW         = $clog2(MAX_FREE);
    localparam int CW         = $clog2(MAX_FREE + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_A_RD, S_A_CMP, S_SHIFT, S_SHIFT_WR, S_BUMP,
        S_F_RD, S_F_CMP, S_F_CHECK, S_F_PUSH, S_RESP
    } state_t;

    state_t      state_reg;
    logic [15:0] addr_reg;
    logic [16:0] size_reg;
    logic [16:0] pool_size_reg;
    logic [16:0] bump_reg;
    logic [CW-1:0] count_reg;
    logic [FW-1:0] idx_reg;
    status_t     res_status_reg;
    logic [15:0] res_addr_reg;
    logic [15:0] res_size_reg;
    logic        res_reuse_reg;
    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    logic          fl_wr_en;
    logic [FW-1:0] fl_wr_addr;
    logic [31:0]   fl_wr_data;
    logic [FW-1:0] fl_rd_addr;
    logic [31:0]   fl_rd_data;
    logic          bs_wr_en;
    logic [SW-1:0] bs_wr_addr;
    logic [SW-1:0] bs_rd_addr;
    logic [15:0]   bs_rd_data;

    logic [16:0] req_round;
    logic [17:0] bump_end;
    logic [15:0] hdr_off;
    logic        cfg_write;
    logic [16:0] cfg_value;

    assign req_round = 17'(((({1'b0, s_axis_tdata[15:0]} + 17'(ALIGN_BYTES - 1))
                       / ALIGN_BYTES) * ALIGN_BYTES));
    assign bump_end  = {1'b0, bump_reg} + 18'(HEADER_BYTES) + {1'b0, size_reg};
    assign hdr_off   = addr_reg - 16'(HEADER_BYTES);

    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign cfg_value = (pwdata[16:0] < MIN_POOL) ? MIN_POOL :
                       (pwdata[16:0] > 17'(POOL_CAP)) ? 17'(POOL_CAP) : pwdata[16:0];
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? 32'd0 : {15'd0, pool_size_reg};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        fl_rd_addr = idx_reg;
        if (state_reg == S_SHIFT) begin
            fl_rd_addr = idx_reg + FW'(1);
        end
        fl_wr_en   = (state_reg == S_SHIFT_WR) || (state_reg == S_F_PUSH);
        fl_wr_addr = (state_reg == S_F_PUSH) ? FW'(count_reg) : idx_reg;
        fl_wr_data = (state_reg == S_F_PUSH) ? {bs_rd_data, addr_reg} : fl_rd_data;
        bs_rd_addr = SW'(hdr_off / ALIGN_BYTES);
        bs_wr_addr = SW'(bump_reg / ALIGN_BYTES);
        bs_wr_en   = (state_reg == S_BUMP) && (bump_end <= {1'b0, pool_size_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pool_size_reg <= 17'(POOL_CAP);
            bump_reg      <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                pool_size_reg <= cfg_value;
            end
            if (m_valid_reg && m_axis_tready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        addr_reg       <= s_axis_tdata[31:16];
                        size_reg       <= req_round;
                        res_status_reg <= ST_OK;
                        res_addr_reg   <= '0;
                        res_size_reg   <= '0;
                        res_reuse_reg  <= 1'b0;
                        if (s_axis_tuser == OP_ALLOC) begin
                            idx_reg <= FW'(count_reg - CW'(1));
                            if (s_axis_tdata[15:0] == 16'd0) begin
                                res_status_reg <= ST_ZERO_SIZE;
                                state_reg      <= S_RESP;
                            end else if ({1'b0, s_axis_tdata[15:0]} > (pool_size_reg >> 1)) begin
                                res_status_reg <= ST_TOO_LARGE;
                                state_reg      <= S_RESP;
                            end else if (count_reg == '0) begin
                                state_reg <= S_BUMP;
                            end else begin
                                state_reg <= S_A_RD;
                            end
                        end else begin
                            idx_reg   <= '0;
                            state_reg <= (count_reg == '0) ? S_F_CHECK : S_F_RD;
                        end
                    end
                end
                S_A_RD: begin
                    state_reg <= S_A_CMP;
                end
                S_A_CMP: begin
                    if ({1'b0, fl_rd_data[31:16]} >= size_reg) begin
                        res_addr_reg  <= fl_rd_data[15:0];
                        res_size_reg  <= fl_rd_data[31:16];
                        res_reuse_reg <= 1'b1;
                        state_reg     <= S_SHIFT;
                    end else if (idx_reg == '0) begin
                        state_reg <= S_BUMP;
                    end else begin
                        idx_reg   <= idx_reg - FW'(1);
                        state_reg <= S_A_RD;
                    end
                end
                S_SHIFT: begin
                    if (CW'(idx_reg) + CW'(1) >= count_reg) begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    idx_reg   <= idx_reg + FW'(1);
                    state_reg <= S_SHIFT;
                end
                S_BUMP: begin
                    if (bump_end <= {1'b0, pool_size_reg}) begin
                        res_addr_reg <= 16'(bump_reg + 17'(HEADER_BYTES));
                        res_size_reg <= size_reg[15:0];
                        bump_reg     <= bump_end[16:0];
                    end else begin
                        res_status_reg <= ST_NO_MEMORY;
                    end
                    state_reg <= S_RESP;
                end
                S_F_RD: begin
                    state_reg <= S_F_CMP;
                end
                S_F_CMP: begin
                    if (fl_rd_data[15:0] == addr_reg) begin
                        res_status_reg <= ST_DOUBLE;
                        state_reg      <= S_RESP;
                    end else if (CW'(idx_reg) + CW'(1) >= count_reg) begin
                        state_reg <= S_F_CHECK;
                    end else begin
                        idx_reg   <= idx_reg + FW'(1);
                        state_reg <= S_F_RD;
                    end
                end
                S_F_CHECK: begin
                    if (addr_reg < 16'(HEADER_BYTES) || {1'b0, hdr_off} >= pool_size_reg) begin
                        res_status_reg <= ST_BAD_ADDR;
                        state_reg      <= S_RESP;
                    end else if (count_reg >= CW'(MAX_FREE)) begin
                        res_status_reg <= ST_LIST_FULL;
                        state_reg      <= S_RESP;
                    end else begin
                        state_reg <= S_F_PUSH;
                    end
                end
                S_F_PUSH: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'd0, res_reuse_reg, res_size_reg,
                                        res_addr_reg, res_status_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    fpa_ram #(.WIDTH(32), .DEPTH(MAX_FREE), .AW(FW)) u_free_list (
        .aclk    (aclk),
        .wr_en   (fl_wr_en),
        .wr_addr (fl_wr_addr),
        .wr_data (fl_wr_data),
        .rd_addr (fl_rd_addr),
        .rd_data (fl_rd_data)
    );

    fpa_ram #(.WIDTH(16), .DEPTH(SIZE_SLOTS), .AW(SW)) u_block_sizes (
        .aclk    (aclk),
        .wr_en   (bs_wr_en),
        .wr_addr (bs_wr_addr),
        .wr_data (size_reg[15:0]),
        .rd_addr (bs_rd_addr),
        .rd_data (bs_rd_data)
    );

endmodule
